// ===== hdl/mmrq_pkg.sv =====
`timescale 1ns / 1ps

package mmrq_pkg;

  // Field widths of the stream payloads.
  localparam int MAILBOX_ID_W = 3;
  localparam int PORT_MAIL_W  = 32;
  localparam int FILL_LEVEL_W = 4;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 40;

  // Operation codes carried in s_tuser.
  localparam logic OP_POST = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PTR,
    ST_MAIL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic s_tready;
    logic ptr_we;
    logic mail_we;
    logic res_load;
    logic mail_load;
    logic out_load;
  } ctrl_t;

endpackage

// ===== hdl/mmrq_ram.sv =====
`timescale 1ns / 1ps

module mmrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/multi_mailbox_ring_queue.sv =====
`timescale 1ns / 1ps
// Flow: a post, or any blocked item, goes from its input transfer through the pointer
// memory read (ST_PTR) to ST_DONE, which loads the output register once it is free; a
// successful take also passes the mail memory read (ST_MAIL). Throughput: one item at a
// time; the output register lets the next item run while a result waits to be taken.
// Reset: synchronous; all mailbox pointers read as empty at once through per-mailbox valid
// bits, with no clearing pass. The mail storage itself is not cleared.
module multi_mailbox_ring_queue #(
  parameter int MAILBOX_COUNT = 8,
  parameter int SLOTS_PER_BOX = 8,
  parameter int MAIL_WIDTH    = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // mailbox_id[2:0], mail_data[34:3], zero padding[39:35]
  input  logic [mmrq_pkg::IN_TDATA_W-1:0]   s_tdata,
  // op[0]
  input  logic [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // taken_mail[31:0], fill_level[35:32], zero padding[39:36]
  output logic [mmrq_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // blocked[0]
  output logic [0:0]                        m_tuser
);

  localparam int BOX_AW  = (MAILBOX_COUNT > 1) ? $clog2(MAILBOX_COUNT) : 1;
  localparam int SW      = $clog2(SLOTS_PER_BOX);
  localparam int CW      = $clog2(SLOTS_PER_BOX + 1);
  localparam int MDEPTH  = MAILBOX_COUNT * SLOTS_PER_BOX;
  localparam int MAW     = $clog2(MDEPTH);
  localparam int MID_W   = mmrq_pkg::MAILBOX_ID_W;
  localparam int PMW     = mmrq_pkg::PORT_MAIL_W;
  localparam int FLW     = mmrq_pkg::FILL_LEVEL_W;

  typedef struct packed {
    logic [CW-1:0] fill;
    logic [SW-1:0] wr;
    logic [SW-1:0] rd;
  } ptr_t;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] slot);
    logic [SW-1:0] n;
    n = slot + SW'(1);
    if (slot == SW'(SLOTS_PER_BOX - 1)) begin
      n = '0;
    end
    return n;
  endfunction

  mmrq_pkg::state_t state, state_next;
  mmrq_pkg::ctrl_t  ctrl;

  // Input unpacking and widening.
  logic [MID_W-1:0]  in_box;
  logic [6:0]        in_box_ext;
  logic [BOX_AW-1:0] in_box_idx;
  logic              in_range;
  logic [63:0]       in_word_ext;
  logic              s_accept;

  assign in_box      = s_tdata[MID_W-1:0];
  assign in_box_ext  = {{(7 - MID_W){1'b0}}, in_box};
  assign in_box_idx  = in_box_ext[BOX_AW-1:0];
  assign in_range    = in_box_ext < 7'(MAILBOX_COUNT);
  assign in_word_ext = {32'd0, s_tdata[MID_W+PMW-1:MID_W]};
  assign s_accept    = s_tvalid && s_tready;

  // Item held while it works through the memories.
  logic                  item_op;
  logic [BOX_AW-1:0]     item_box;
  logic                  item_in_range;
  logic [MAIL_WIDTH-1:0] item_word;
  logic                  item_ptr_valid;

  logic [MAILBOX_COUNT-1:0] ptr_valid;

  // Pending result.
  logic [PMW-1:0] res_mail;
  logic           res_blocked;
  logic [FLW-1:0] res_fill;

  // Pointer memory.
  ptr_t ptr_rdata, cur_ptr, new_ptr;

  mmrq_ram #(
    .WIDTH($bits(ptr_t)),
    .DEPTH(MAILBOX_COUNT)
  ) u_ptr_ram (
    .clk  (clk),
    .we   (ctrl.ptr_we),
    .waddr(item_box),
    .wdata(new_ptr),
    .raddr(in_box_idx),
    .rdata(ptr_rdata)
  );

  // A mailbox never written since reset reads as empty.
  assign cur_ptr = item_ptr_valid ? ptr_rdata : '0;

  logic take_ok, post_ok, item_ok;
  logic [CW-1:0]  fill_after;
  logic [8:0]     fill_ext;
  logic [MAW-1:0] mail_addr;

  always_comb begin
    take_ok = item_in_range && (item_op == mmrq_pkg::OP_TAKE) && (cur_ptr.fill != '0);
    post_ok = item_in_range && (item_op == mmrq_pkg::OP_POST) &&
              (cur_ptr.fill != CW'(SLOTS_PER_BOX));
    item_ok = take_ok || post_ok;

    new_ptr = cur_ptr;
    if (take_ok) begin
      new_ptr.fill = cur_ptr.fill - CW'(1);
      new_ptr.rd   = next_slot(cur_ptr.rd);
    end else if (post_ok) begin
      new_ptr.fill = cur_ptr.fill + CW'(1);
      new_ptr.wr   = next_slot(cur_ptr.wr);
    end

    if (!item_in_range) begin
      fill_after = '0;
    end else if (item_ok) begin
      fill_after = new_ptr.fill;
    end else begin
      fill_after = cur_ptr.fill;
    end
    fill_ext = '0;
    fill_ext[CW-1:0] = fill_after;

    mail_addr = MAW'(item_box) * MAW'(SLOTS_PER_BOX) +
                MAW'((item_op == mmrq_pkg::OP_TAKE) ? cur_ptr.rd : cur_ptr.wr);
  end

  // Mail memory.
  logic [MAIL_WIDTH-1:0] mail_rdata;
  logic [63:0]           mail_rdata_ext;

  mmrq_ram #(
    .WIDTH(MAIL_WIDTH),
    .DEPTH(MDEPTH)
  ) u_mail_ram (
    .clk  (clk),
    .we   (ctrl.mail_we),
    .waddr(mail_addr),
    .wdata(item_word),
    .raddr(mail_addr),
    .rdata(mail_rdata)
  );

  always_comb begin
    mail_rdata_ext = '0;
    mail_rdata_ext[MAIL_WIDTH-1:0] = mail_rdata;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmrq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      mmrq_pkg::ST_IDLE: begin
        ctrl.s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = mmrq_pkg::ST_PTR;
        end
      end
      mmrq_pkg::ST_PTR: begin
        ctrl.ptr_we   = item_ok;
        ctrl.mail_we  = post_ok;
        ctrl.res_load = 1'b1;
        state_next    = take_ok ? mmrq_pkg::ST_MAIL : mmrq_pkg::ST_DONE;
      end
      mmrq_pkg::ST_MAIL: begin
        ctrl.mail_load = 1'b1;
        state_next     = mmrq_pkg::ST_DONE;
      end
      mmrq_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          ctrl.out_load = 1'b1;
          state_next    = mmrq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mmrq_pkg::ST_IDLE;
      end
    endcase
  end

  assign s_tready = ctrl.s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_valid <= '0;
    end else if (ctrl.ptr_we) begin
      ptr_valid[item_box] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      item_op        <= s_tuser[0];
      item_box       <= in_box_idx;
      item_in_range  <= in_range;
      item_word      <= in_word_ext[MAIL_WIDTH-1:0];
      item_ptr_valid <= in_range && ptr_valid[in_box_idx];
    end
    if (ctrl.res_load) begin
      res_mail    <= '0;
      res_blocked <= !item_ok;
      res_fill    <= fill_ext[FLW-1:0];
    end
    if (ctrl.mail_load) begin
      res_mail <= mail_rdata_ext[PMW-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      m_tdata    <= {{(mmrq_pkg::OUT_TDATA_W - PMW - FLW){1'b0}}, res_fill, res_mail};
      m_tuser[0] <= res_blocked;
    end
  end

  // A blocked result never carries a mail word.
  a_blocked_no_mail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[PMW-1:0] == '0)
    else $error("blocked result carries a mail word");

  // The output register is loaded only when its previous result has gone.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> (!m_tvalid || m_tready))
    else $error("output result overwritten before transfer");

  // One item at a time: after an input transfer the engine is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_tready)
    else $error("input accepted while an item is in flight");

endmodule
